// ===== hw/rtl/rrack_pkg.sv =====
// Shared types and codes for the reorder receiver.
`default_nettype none
package rrack_pkg;
  localparam int unsigned HANDLE_BITS = 10;
  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned ACK_EVERY_W = 11;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [2:0] ACT_REPLY_START = 3'd0;
  localparam logic [2:0] ACT_REPLY_FIN = 3'd1;
  localparam logic [2:0] ACT_DELIVER = 3'd2;
  localparam logic [2:0] ACT_ACK = 3'd3;
  localparam logic [2:0] ACT_NACK = 3'd4;
  localparam logic [2:0] ACT_DROP = 3'd5;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FIN = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_EOF = 2'd3;

  localparam logic MODE_TICK = 1'b1;

  localparam logic [1:0] CFG_ACK_EVERY = 2'd0;
  localparam logic [1:0] CFG_NACK_THR = 2'd1;
  localparam logic [1:0] CFG_NACK_TMO = 2'd2;
  localparam logic [1:0] CFG_QUEUE_LIM = 2'd3;

  typedef struct packed {
    logic                   mode;
    logic [1:0]             pkt_kind;
    logic [31:0]            seq_in;
    logic [HANDLE_BITS-1:0] buf_handle;
  } in_t;

  typedef struct packed {
    logic [2:0]             action;
    logic [31:0]            seq_out;
    logic [31:0]            low_held_seq;
    logic [HANDLE_BITS-1:0] handle_out;
    logic                   is_eof;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [31:0]            seq;
    logic                   eof;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rrack_rem.sv =====
// Bit-serial remainder check of a sequence against the ack interval.
`default_nettype none
module rrack_rem (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic [31:0]                          dividend_i,
  input  logic [rrack_pkg::ACK_EVERY_W-1:0]    divisor_i,
  output rrack_pkg::rem_stat_t                 stat_o
);
  import rrack_pkg::*;

  logic [ACK_EVERY_W-1:0] rem_q, rem_d;
  logic [31:0]            dvd_q, dvd_d;
  logic [5:0]             cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [ACK_EVERY_W:0]   trial;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    trial = {rem_q, dvd_q[31]};
    if (trial >= {1'b0, divisor_i}) begin
      trial = trial - {1'b0, divisor_i};
    end
    if (go_i) begin
      rem_d = '0;
      dvd_d = dividend_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      rem_d = trial[ACK_EVERY_W-1:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);
endmodule
`default_nettype wire

// ===== hw/rtl/reorder_receiver_ack_nack.sv =====
// Top level of the reorder receiver with ack and nack generation.
`default_nettype none
// Takes one packet header or millisecond tick per start pulse, until a finish packet
// has been taken, and raises busy until its results are out; results appear one per
// strobe cycle on res_valid_o and cannot be stalled, the final one of an item carrying
// last. Held packets live in a circular memory with registered reads; an item's time
// grows with the held entries walked in the sorted search, the entries shifted on
// insert and the packets drained, and an in-order payload waits for the ack remainder.
module reorder_receiver_ack_nack #(
  parameter int unsigned QUEUE_DEPTH = rrack_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  rrack_pkg::in_t                       in_i,
  output logic                                 res_valid_o,
  output rrack_pkg::res_t                      res_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [rrack_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rrack_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ACK, S_DIV, S_DR_RD, S_DR_CMP, S_DR_END, S_SR_RD, S_SR_CMP,
    S_INS, S_SH, S_SH_WR, S_NK_CHK, S_NK_RD, S_NK, S_DONE
  } state_e;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [ACK_EVERY_W-1:0] cfg_ack_q;
  logic [5:0]             cfg_thr_q;
  logic [15:0]            cfg_tmo_q;
  logic [5:0]             cfg_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ack_q <= ACK_EVERY_W'(10);
      cfg_thr_q <= 6'd5;
      cfg_tmo_q <= 16'd1000;
      cfg_lim_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_EVERY: cfg_ack_q <= cfg_data_i[ACK_EVERY_W-1:0];
        CFG_NACK_THR:  cfg_thr_q <= cfg_data_i[5:0];
        CFG_NACK_TMO:  cfg_tmo_q <= cfg_data_i;
        CFG_QUEUE_LIM: cfg_lim_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  slot_t              mem [QUEUE_DEPTH];
  slot_t              rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  slot_t              mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  state_e             state_q, state_d;
  in_t                in_q, in_d;
  logic [CW-1:0]      held_q, held_d;
  logic [AW-1:0]      head_q, head_d;
  logic [31:0]        exp_q, exp_d;
  logic               armed_q, armed_d;
  logic [15:0]        ms_q, ms_d;
  logic               fin_q, fin_d;
  logic [CW-1:0]      p_q, p_d;
  logic [CW-1:0]      i_q, i_d;
  logic               drained_q, drained_d;
  logic [31:0]        lastdr_q, lastdr_d;
  res_t               pend_q, pend_d;
  logic               pend_v_q, pend_v_d;
  res_t               out_q, out_d;
  logic               out_v_q, out_v_d;

  logic               push;
  res_t               push_r;
  logic               rem_go;
  rem_stat_t          rem_stat;
  logic [ACK_EVERY_W-1:0] divisor;
  logic [31:0]        lim32;
  logic               accept;
  logic               timed_out;
  slot_t              new_slot;

  assign divisor = (cfg_ack_q == '0) ? ACK_EVERY_W'(1) : cfg_ack_q;
  assign lim32 = (32'(cfg_lim_q) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : 32'(cfg_lim_q);
  assign accept = start && !busy;
  assign timed_out = armed_q && (ms_q > cfg_tmo_q);
  assign new_slot = '{seq: in_q.seq_in, eof: (in_q.pkt_kind == KIND_EOF),
                      handle: in_q.buf_handle};

  rrack_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (rem_go),
    .dividend_i (in_q.seq_in),
    .divisor_i  (divisor),
    .stat_o     (rem_stat)
  );

  always_comb begin
    state_d = state_q;
    in_d = in_q;
    held_d = held_q;
    head_d = head_q;
    exp_d = exp_q;
    armed_d = armed_q;
    ms_d = ms_q;
    fin_d = fin_q;
    p_d = p_q;
    i_d = i_q;
    drained_d = drained_q;
    lastdr_d = lastdr_q;
    push = 1'b0;
    push_r = '0;
    rem_go = 1'b0;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_slot;
    mem_raddr = head_q;
    pend_d = pend_q;
    pend_v_d = pend_v_q;
    out_d = out_q;
    out_v_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept && !fin_q) begin
          in_d = in_i;
          if (in_i.mode == MODE_TICK) begin
            ms_d = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;
            state_d = (armed_q && (ms_d > cfg_tmo_q)) ? S_NK_RD : S_DONE;
          end else if (in_i.pkt_kind == KIND_START) begin
            push = 1'b1;
            push_r.action = ACT_REPLY_START;
            state_d = S_DONE;
          end else if (in_i.pkt_kind == KIND_FIN) begin
            push = 1'b1;
            push_r.action = ACT_REPLY_FIN;
            fin_d = 1'b1;
            state_d = S_DONE;
          end else if (in_i.seq_in == exp_q) begin
            push = 1'b1;
            push_r.action = ACT_DELIVER;
            push_r.seq_out = in_i.seq_in;
            push_r.handle_out = in_i.buf_handle;
            push_r.is_eof = (in_i.pkt_kind == KIND_EOF);
            exp_d = exp_q + 32'd1;
            armed_d = 1'b0;
            drained_d = 1'b0;
            state_d = S_ACK;
          end else if (in_i.seq_in > exp_q) begin
            p_d = '0;
            state_d = S_SR_RD;
          end else begin
            push = 1'b1;
            push_r.action = ACT_ACK;
            push_r.seq_out = in_i.seq_in;
            state_d = S_DONE;
          end
        end
      end
      S_ACK: begin
        if (in_q.pkt_kind == KIND_EOF) begin
          push = 1'b1;
          push_r.action = ACT_ACK;
          push_r.seq_out = in_q.seq_in;
          state_d = S_DR_RD;
        end else begin
          rem_go = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            push = 1'b1;
            push_r.action = ACT_ACK;
            push_r.seq_out = in_q.seq_in;
          end
          state_d = S_DR_RD;
        end
      end
      S_DR_RD: begin
        mem_raddr = head_q;
        state_d = (held_q != '0) ? S_DR_CMP : S_DR_END;
      end
      S_DR_CMP: begin
        if (rd_q.seq == exp_q) begin
          push = 1'b1;
          push_r.action = ACT_DELIVER;
          push_r.seq_out = rd_q.seq;
          push_r.handle_out = rd_q.handle;
          push_r.is_eof = rd_q.eof;
          lastdr_d = exp_q;
          drained_d = 1'b1;
          exp_d = exp_q + 32'd1;
          held_d = held_q - CW'(1);
          head_d = phys(head_q, AW'(1));
          state_d = S_DR_RD;
        end else begin
          state_d = S_DR_END;
        end
      end
      S_DR_END: begin
        if (drained_q) begin
          push = 1'b1;
          push_r.action = ACT_ACK;
          push_r.seq_out = lastdr_q;
        end
        state_d = S_DONE;
      end
      S_SR_RD: begin
        mem_raddr = phys(head_q, p_q[AW-1:0]);
        state_d = (p_q < held_q) ? S_SR_CMP : S_INS;
      end
      S_SR_CMP: begin
        if (rd_q.seq < in_q.seq_in) begin
          p_d = p_q + CW'(1);
          state_d = S_SR_RD;
        end else if (rd_q.seq == in_q.seq_in) begin
          mem_we = 1'b1;
          mem_waddr = phys(head_q, p_q[AW-1:0]);
          state_d = S_NK_CHK;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (32'(held_q) < lim32) begin
          i_d = held_q;
          state_d = S_SH;
        end else begin
          push = 1'b1;
          push_r.action = ACT_DROP;
          push_r.seq_out = in_q.seq_in;
          push_r.handle_out = in_q.buf_handle;
          state_d = S_NK_CHK;
        end
      end
      S_SH: begin
        if (i_q > p_q) begin
          mem_raddr = phys(head_q, AW'(i_q - CW'(1)));
          state_d = S_SH_WR;
        end else begin
          mem_we = 1'b1;
          mem_waddr = phys(head_q, p_q[AW-1:0]);
          held_d = held_q + CW'(1);
          state_d = S_NK_CHK;
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        mem_waddr = phys(head_q, i_q[AW-1:0]);
        mem_wdata = rd_q;
        i_d = i_q - CW'(1);
        state_d = S_SH;
      end
      S_NK_CHK: begin
        state_d = ((32'(held_q) == 32'(cfg_thr_q)) || timed_out) ? S_NK_RD : S_DONE;
      end
      S_NK_RD: begin
        mem_raddr = head_q;
        state_d = (held_q != '0) ? S_NK : S_DONE;
      end
      S_NK: begin
        push = 1'b1;
        push_r.action = ACT_NACK;
        push_r.seq_out = exp_q;
        push_r.low_held_seq = rd_q.seq;
        armed_d = 1'b1;
        ms_d = '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        out_v_d = pend_v_q;
        out_d = pend_q;
        out_d.last = 1'b1;
        pend_v_d = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (push) begin
      out_v_d = pend_v_q;
      out_d = pend_q;
      out_d.last = 1'b0;
      pend_d = push_r;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q <= '0;
      head_q <= '0;
      exp_q <= '0;
      armed_q <= 1'b0;
      ms_q <= '0;
      fin_q <= 1'b0;
      drained_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q <= held_d;
      head_q <= head_d;
      exp_q <= exp_d;
      armed_q <= armed_d;
      ms_q <= ms_d;
      fin_q <= fin_d;
      drained_q <= drained_d;
      pend_v_q <= pend_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    p_q <= p_d;
    i_q <= i_d;
    lastdr_q <= lastdr_d;
    pend_q <= pend_d;
    out_q <= out_d;
  end

  assign busy = (state_q != S_IDLE);
  assign res_valid_o = out_v_q;
  assign res_o = out_q;

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= 32'(QUEUE_DEPTH))
    else $error("held count beyond queue depth");
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("result right after last transfer");
  a_fin_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin_q) |=> (!res_valid_o && !busy))
    else $error("activity after finish");
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("pending result left in idle");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/reorder_receiver_ack_nack_test.sv =====
// Testbench for the reorder receiver: directed and random packet streams checked against a predictor.
`timescale 1ns / 100ps
module reorder_receiver_ack_nack_test;
  import rrack_pkg::*;

  localparam int unsigned DEPTH = 32;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_t             in_i = '0;
  logic            res_valid_o;
  res_t            res_o;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  reorder_receiver_ack_nack dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] held_seq [DEPTH];
  logic        held_eof [DEPTH];
  logic [HANDLE_BITS-1:0] held_hdl [DEPTH];
  int unsigned held_n;
  logic [31:0] next_seq;
  bit          nack_on;
  int unsigned ms_count;
  bit          done_flag;
  int unsigned r_ack_every, r_nack_thr, r_nack_tmo, r_queue_lim;

  res_t pending_results[$];
  int   fail_count;
  int   sent_count;
  int   got_count;

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      got_count++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: action %0d", res_o.action);
        fail_count++;
      end else begin
        res_t e;
        e = pending_results.pop_front();
        if (res_o.action !== e.action) begin
          $error("action exp %0d got %0d", e.action, res_o.action); fail_count++;
        end
        if (res_o.seq_out !== e.seq_out) begin
          $error("seq_out exp %0h got %0h", e.seq_out, res_o.seq_out); fail_count++;
        end
        if (res_o.low_held_seq !== e.low_held_seq) begin
          $error("low_held_seq exp %0h got %0h", e.low_held_seq, res_o.low_held_seq);
          fail_count++;
        end
        if (res_o.handle_out !== e.handle_out) begin
          $error("handle_out exp %0h got %0h", e.handle_out, res_o.handle_out); fail_count++;
        end
        if (res_o.is_eof !== e.is_eof) begin
          $error("is_eof exp %0b got %0b", e.is_eof, res_o.is_eof); fail_count++;
        end
        if (res_o.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, res_o.last); fail_count++;
        end
      end
    end
  end

  function automatic void push_result(ref res_t q[$], input logic [2:0] act,
                                      input logic [31:0] s, input logic [31:0] h,
                                      input logic [HANDLE_BITS-1:0] hd, input logic eof);
    res_t r;
    r.action = act; r.seq_out = s; r.low_held_seq = h; r.handle_out = hd;
    r.is_eof = eof; r.last = 1'b0;
    q.push_back(r);
  endfunction

  function automatic void raise_nack(ref res_t q[$]);
    if (held_n == 0) return;
    push_result(q, ACT_NACK, next_seq, held_seq[0], '0, 1'b0);
    nack_on = 1'b1;
    ms_count = 0;
  endfunction

  function automatic void predict_receive(input in_t it);
    res_t q[$];
    int unsigned divisor, lim, p;
    bit drained;
    logic [31:0] last_seq;
    if (done_flag) return;
    if (it.mode == MODE_TICK) begin
      if (ms_count < 65535) ms_count++;
      if (nack_on && ms_count > r_nack_tmo) raise_nack(q);
    end else if (it.pkt_kind == KIND_START) begin
      push_result(q, ACT_REPLY_START, '0, '0, '0, 1'b0);
    end else if (it.pkt_kind == KIND_FIN) begin
      done_flag = 1'b1;
      push_result(q, ACT_REPLY_FIN, '0, '0, '0, 1'b0);
    end else if (it.seq_in == next_seq) begin
      divisor = r_ack_every ? r_ack_every : 1;
      drained = 1'b0;
      last_seq = '0;
      push_result(q, ACT_DELIVER, it.seq_in, '0, it.buf_handle, it.pkt_kind == KIND_EOF);
      next_seq++;
      nack_on = 1'b0;
      if (it.pkt_kind == KIND_EOF || it.seq_in % divisor == 0)
        push_result(q, ACT_ACK, it.seq_in, '0, '0, 1'b0);
      while (held_n > 0 && held_seq[0] == next_seq) begin
        push_result(q, ACT_DELIVER, held_seq[0], '0, held_hdl[0], held_eof[0]);
        last_seq = next_seq;
        drained = 1'b1;
        next_seq++;
        held_n--;
        for (int i = 0; i < held_n; i++) begin
          held_seq[i] = held_seq[i+1]; held_eof[i] = held_eof[i+1];
          held_hdl[i] = held_hdl[i+1];
        end
      end
      if (drained) push_result(q, ACT_ACK, last_seq, '0, '0, 1'b0);
    end else if (it.seq_in > next_seq) begin
      lim = r_queue_lim > DEPTH ? DEPTH : r_queue_lim;
      p = 0;
      while (p < held_n && held_seq[p] < it.seq_in) p++;
      if (p < held_n && held_seq[p] == it.seq_in) begin
        held_eof[p] = it.pkt_kind == KIND_EOF;
        held_hdl[p] = it.buf_handle;
      end else if (held_n < lim) begin
        for (int i = int'(held_n); i > int'(p); i--) begin
          held_seq[i] = held_seq[i-1]; held_eof[i] = held_eof[i-1];
          held_hdl[i] = held_hdl[i-1];
        end
        held_seq[p] = it.seq_in;
        held_eof[p] = it.pkt_kind == KIND_EOF;
        held_hdl[p] = it.buf_handle;
        held_n++;
      end else begin
        push_result(q, ACT_DROP, it.seq_in, '0, it.buf_handle, 1'b0);
      end
      if (held_n == r_nack_thr || (nack_on && ms_count > r_nack_tmo)) raise_nack(q);
    end else begin
      push_result(q, ACT_ACK, it.seq_in, '0, '0, 1'b0);
    end
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
    foreach (q[i]) pending_results.push_back(q[i]);
  endfunction

  task automatic send_item(input in_t it, input bit gaps = 1'b1);
    int unsigned pause;
    pause = gaps && ($urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : 0;
    repeat (pause) @(posedge clk_i);
    start <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_receive(it);
    sent_count++;
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pkt(input logic [1:0] kind, input logic [31:0] s,
                          input logic [HANDLE_BITS-1:0] h);
    in_t it;
    it.mode = 1'b0; it.pkt_kind = kind; it.seq_in = s; it.buf_handle = h;
    send_item(it);
  endtask

  task automatic send_tick();
    in_t it;
    it = '0;
    it.mode = MODE_TICK;
    it.pkt_kind = 2'($urandom);
    it.seq_in = $urandom();
    it.buf_handle = HANDLE_BITS'($urandom);
    send_item(it, 1'b0);
  endtask

  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i); guard++;
    end
    while (busy) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACK_EVERY: r_ack_every = val & 11'h7ff;
      CFG_NACK_THR:  r_nack_thr = val & 6'h3f;
      CFG_NACK_TMO:  r_nack_tmo = val & 16'hffff;
      default:       r_queue_lim = val & 6'h3f;
    endcase
  endtask

  task automatic test_directed();
    send_pkt(KIND_START, 32'hffff_ffff, 10'h3ff);
    send_pkt(KIND_DATA, 0, 10'h000);
    send_pkt(KIND_DATA, 3, 10'h3ff);
    send_pkt(KIND_DATA, 3, 10'h155);
    send_pkt(KIND_EOF, 5, 10'h2aa);
    send_pkt(KIND_DATA, 2, 10'h011);
    send_pkt(KIND_DATA, 0, 10'h022);
    send_pkt(KIND_DATA, 32'hffff_ffff, 10'h033);
    for (int i = 7; i < 11; i++) send_pkt(KIND_DATA, i, HANDLE_BITS'(i));
    repeat (3) send_tick();
    send_pkt(KIND_DATA, 1, 10'h044);
    send_pkt(KIND_DATA, 4, 10'h055);
    send_pkt(KIND_DATA, 6, 10'h066);
    send_pkt(KIND_DATA, 11, 10'h077);
  endtask

  task automatic test_queue_limits();
    write_reg(CFG_QUEUE_LIM, 2);
    write_reg(CFG_NACK_THR, 1);
    write_reg(CFG_NACK_TMO, 1);
    write_reg(CFG_ACK_EVERY, 1);
    for (int i = 0; i < 5; i++)
      send_pkt(KIND_DATA, next_seq + 2 + i, HANDLE_BITS'($urandom));
    send_pkt(KIND_DATA, next_seq + 3, 10'h3c3);
    repeat (4) send_tick();
    send_pkt(KIND_DATA, next_seq + 1, 10'h111);
    send_pkt(KIND_DATA, next_seq, 10'h222);
    write_reg(CFG_QUEUE_LIM, 0);
    send_pkt(KIND_DATA, next_seq + 1, 10'h333);
    write_reg(CFG_QUEUE_LIM, 63);
    write_reg(CFG_ACK_EVERY, 0);
    send_pkt(KIND_DATA, next_seq, 10'h001);
    write_reg(CFG_ACK_EVERY, 1024);
    write_reg(CFG_NACK_TMO, 65535);
    write_reg(CFG_NACK_THR, 32);
  endtask

  task automatic test_random_stream();
    int unsigned window;
    for (int n = 0; n < 120; n++) begin
      if (n % 40 == 0) begin
        drain_results();
        write_reg(CFG_ACK_EVERY, $urandom_range(1, 12));
        write_reg(CFG_NACK_THR, $urandom_range(1, 8));
        write_reg(CFG_NACK_TMO, $urandom_range(1, 6));
        write_reg(CFG_QUEUE_LIM, $urandom_range(n == 80 ? 32 : 3, 32));
      end
      window = $urandom_range(0, 9);
      case ($urandom_range(0, 19))
        0: send_pkt(KIND_START, $urandom, HANDLE_BITS'($urandom));
        1, 2, 3: send_tick();
        4: send_pkt($urandom_range(0, 1) != 0 ? KIND_EOF : KIND_DATA,
                    next_seq - $urandom_range(1, 4), HANDLE_BITS'($urandom));
        5: send_pkt(KIND_DATA, $urandom, HANDLE_BITS'($urandom));
        6, 7, 8, 9: send_pkt(KIND_DATA, next_seq, HANDLE_BITS'($urandom));
        default: send_pkt($urandom_range(0, 9) == 0 ? KIND_EOF : KIND_DATA,
                          next_seq + window, HANDLE_BITS'($urandom));
      endcase
    end
  endtask

  task automatic test_finish();
    send_pkt(KIND_FIN, $urandom, HANDLE_BITS'($urandom));
    send_pkt(KIND_DATA, next_seq, 10'h1);
    send_tick();
    send_pkt(KIND_START, 0, 0);
  endtask

  initial begin
    held_n = 0; next_seq = '0; nack_on = 0; ms_count = 0; done_flag = 0;
    r_ack_every = 10; r_nack_thr = 5; r_nack_tmo = 1000; r_queue_lim = 32;
    fail_count = 0; sent_count = 0; got_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_queue_limits();
    test_random_stream();
    drain_results();
    test_finish();
    drain_results();
    $display("Sent %0d items (ticks, starts, in-order, held, stale, drops, finish)", sent_count);
    $display("Checked %0d results over several register settings", got_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
